/* rtl/fds_pkg.sv */
// Shared types and constants for the frame/draw statistics window.
// No dependencies; imported by every module of the block.
package fds_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned LEN_W      = 10;
  localparam int unsigned FPS_W      = 27;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DIV_CNT_W  = $clog2(DATA_W);

  localparam logic [LEN_W-1:0]  WIN_LEN_RESET = LEN_W'(300);
  localparam logic [DATA_W-1:0] ALL_ONES      = {DATA_W{1'b1}};
  localparam int unsigned       FPS_SCALE     = 100000;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_PLAIN   = 2'd1,
    CMD_INDEXED = 2'd2,
    CMD_END     = 2'd3
  } fds_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_DONE
  } fds_state_e;

  // One closed frame, with the window snapshot taken at its end.
  typedef struct packed {
    logic [DATA_W-1:0] frame_index;
    logic [DATA_W-1:0] plain_draws;
    logic [DATA_W-1:0] indexed_draws;
    logic [DATA_W-1:0] duration_ms;
    logic              summary;
    logic [LEN_W-1:0]  win_frames;
    logic [DATA_W-1:0] win_duration_ms;
    logic [DATA_W-1:0] min_draws;
    logic [DATA_W-1:0] max_draws;
    logic [DATA_W-1:0] plain_sum;
    logic [DATA_W-1:0] indexed_sum;
  } fds_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fds_qstat_t;

endpackage

/* rtl/fds_front.sv */
// Front end: takes events, keeps per-frame and per-window counters, and
// pushes one entry per frame end into the queue. Depends on fds_pkg.
module fds_front
  import fds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [DATA_W-1:0] time_ms_i,
  input  fds_qstat_t        qstat_i,
  output logic              push_o,
  output fds_entry_t        entry_o
);

  logic [LEN_W-1:0]  win_len_q, win_len_d;
  logic [DATA_W-1:0] frames_seen_q, frames_seen_d;
  logic [DATA_W-1:0] plain_q, plain_d;
  logic [DATA_W-1:0] indexed_q, indexed_d;
  logic [DATA_W-1:0] frame_start_q, frame_start_d;
  logic [LEN_W-1:0]  win_frames_q, win_frames_d;
  logic [DATA_W-1:0] win_start_q, win_start_d;
  logic [DATA_W-1:0] plain_sum_q, plain_sum_d;
  logic [DATA_W-1:0] indexed_sum_q, indexed_sum_d;
  logic [DATA_W-1:0] min_q, min_d;
  logic [DATA_W-1:0] max_q, max_d;

  logic              accept;
  logic [DATA_W-1:0] draws;
  logic [LEN_W-1:0]  frames_inc;
  logic [DATA_W-1:0] plain_sum_inc;
  logic [DATA_W-1:0] indexed_sum_inc;
  logic [DATA_W-1:0] min_new;
  logic [DATA_W-1:0] max_new;
  logic [DATA_W-1:0] win_dt;
  logic              close;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && (cmd_i == CMD_END);

  assign draws           = plain_q + indexed_q;
  assign frames_inc      = win_frames_q + LEN_W'(1);
  assign plain_sum_inc   = plain_sum_q + plain_q;
  assign indexed_sum_inc = indexed_sum_q + indexed_q;
  assign min_new         = (draws < min_q) ? draws : min_q;
  assign max_new         = (draws > max_q) ? draws : max_q;
  assign close           = (frames_inc >= win_len_q);

  always_comb begin
    win_dt = time_ms_i - win_start_q;
    // a zero-length window counts as one millisecond
    if (win_dt == '0) begin
      win_dt = DATA_W'(1);
    end
  end

  always_comb begin
    entry_o.frame_index     = frames_seen_q;
    entry_o.plain_draws     = plain_q;
    entry_o.indexed_draws   = indexed_q;
    entry_o.duration_ms     = time_ms_i - frame_start_q;
    entry_o.summary         = close;
    entry_o.win_frames      = frames_inc;
    entry_o.win_duration_ms = win_dt;
    entry_o.min_draws       = min_new;
    entry_o.max_draws       = max_new;
    entry_o.plain_sum       = plain_sum_inc;
    entry_o.indexed_sum     = indexed_sum_inc;
  end

  always_comb begin
    win_len_d     = cfg_we_i ? cfg_wdata_i : win_len_q;
    frames_seen_d = frames_seen_q;
    plain_d       = plain_q;
    indexed_d     = indexed_q;
    frame_start_d = frame_start_q;
    win_frames_d  = win_frames_q;
    win_start_d   = win_start_q;
    plain_sum_d   = plain_sum_q;
    indexed_sum_d = indexed_sum_q;
    min_d         = min_q;
    max_d         = max_q;
    if (accept) begin
      unique case (cmd_i)
        CMD_BEGIN: begin
          // a frame begin before the first frame end restarts the window
          if (frames_seen_q == '0) begin
            win_frames_d  = '0;
            win_start_d   = time_ms_i;
            plain_sum_d   = '0;
            indexed_sum_d = '0;
            min_d         = ALL_ONES;
            max_d         = '0;
          end
          plain_d       = '0;
          indexed_d     = '0;
          frame_start_d = time_ms_i;
        end
        CMD_PLAIN: begin
          plain_d = plain_q + DATA_W'(1);
        end
        CMD_INDEXED: begin
          indexed_d = indexed_q + DATA_W'(1);
        end
        CMD_END: begin
          frames_seen_d = frames_seen_q + DATA_W'(1);
          if (close) begin
            win_frames_d  = '0;
            win_start_d   = time_ms_i;
            plain_sum_d   = '0;
            indexed_sum_d = '0;
            min_d         = ALL_ONES;
            max_d         = '0;
          end else begin
            win_frames_d  = frames_inc;
            plain_sum_d   = plain_sum_inc;
            indexed_sum_d = indexed_sum_inc;
            min_d         = min_new;
            max_d         = max_new;
          end
        end
        default: begin
          frames_seen_d = frames_seen_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q     <= WIN_LEN_RESET;
      frames_seen_q <= '0;
      plain_q       <= '0;
      indexed_q     <= '0;
      frame_start_q <= '0;
      win_frames_q  <= '0;
      win_start_q   <= '0;
      plain_sum_q   <= '0;
      indexed_sum_q <= '0;
      min_q         <= ALL_ONES;
      max_q         <= '0;
    end else begin
      win_len_q     <= win_len_d;
      frames_seen_q <= frames_seen_d;
      plain_q       <= plain_d;
      indexed_q     <= indexed_d;
      frame_start_q <= frame_start_d;
      win_frames_q  <= win_frames_d;
      win_start_q   <= win_start_d;
      plain_sum_q   <= plain_sum_d;
      indexed_sum_q <= indexed_sum_d;
      min_q         <= min_d;
      max_q         <= max_d;
    end
  end

endmodule

/* rtl/fds_queue.sv */
// Short FIFO of closed-frame entries between front and back end.
// Depends on fds_pkg.
module fds_queue
  import fds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fds_entry_t entry_i,
  input  logic       pop_i,
  output fds_entry_t head_o,
  output fds_qstat_t qstat_o
);

  fds_entry_t        entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign qstat_o.empty = (count_q == '0);
  assign head_o        = entries_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    ptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + QCNT_W'(1);
      2'b01:   count_d = count_q - QCNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> !qstat_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + QCNT_W'(1))
    else $error("queue count did not follow push");

endmodule

/* rtl/fds_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on fds_pkg.
module fds_div
  import fds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    dsr_q, dsr_d;
  logic [DATA_W:0]      rem_shift;
  logic [DATA_W:0]      rem_sub;
  logic                 fits;

  assign rem_shift  = {rem_q, quo_q[DATA_W-1]};
  assign rem_sub    = rem_shift - {1'b0, dsr_q};
  assign fits       = (rem_shift >= {1'b0, dsr_q});
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DATA_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit in; the quotient bit fills the vacated LSB
      rem_d = fits ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      quo_d = {quo_q[DATA_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

endmodule

/* rtl/fds_back.sv */
// Back end: pops frame entries, runs the window divisions when a window
// closes, and holds the result in the output register. Depends on fds_pkg, fds_div.
module fds_back
  import fds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fds_qstat_t        qstat_i,
  input  fds_entry_t        head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] frame_index_o,
  output logic [DATA_W-1:0] frame_plain_draws_o,
  output logic [DATA_W-1:0] frame_indexed_draws_o,
  output logic [DATA_W-1:0] frame_duration_ms_o,
  output logic              summary_valid_o,
  output logic [LEN_W-1:0]  window_frames_o,
  output logic [DATA_W-1:0] window_duration_ms_o,
  output logic [FPS_W-1:0]  fps_hundredths_o,
  output logic [DATA_W-1:0] min_draws_o,
  output logic [DATA_W-1:0] max_draws_o,
  output logic [DATA_W-1:0] avg_plain_draws_o,
  output logic [DATA_W-1:0] avg_indexed_draws_o
);

  fds_state_e state_q, state_d;
  fds_entry_t work_q;
  logic       out_valid_q, out_valid_d;
  logic       load_out;
  logic       div_start;
  logic       div_busy;
  logic       out_free;
  logic       has_frames;

  logic [FPS_W-1:0]  fps_dividend;
  logic [DATA_W-1:0] frames_wide;
  logic              busy_fps, busy_plain, busy_indexed;
  logic [DATA_W-1:0] quo_fps, quo_plain, quo_indexed;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign div_busy     = busy_fps || busy_plain || busy_indexed;
  assign frames_wide  = DATA_W'(work_q.win_frames);
  assign has_frames   = (work_q.win_frames != '0);
  assign fps_dividend = FPS_W'(work_q.win_frames) * FPS_W'(FPS_SCALE);

  fds_div u_div_fps (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DATA_W'(fps_dividend)),
    .divisor_i  (work_q.win_duration_ms),
    .busy_o     (busy_fps),
    .quotient_o (quo_fps)
  );

  fds_div u_div_plain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (work_q.plain_sum),
    .divisor_i  (frames_wide),
    .busy_o     (busy_plain),
    .quotient_o (quo_plain)
  );

  fds_div u_div_indexed (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (work_q.indexed_sum),
    .divisor_i  (frames_wide),
    .busy_o     (busy_indexed),
    .quotient_o (quo_indexed)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          state_d = head_i.summary ? ST_START : ST_DONE;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (!div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE:  pop_o     = !qstat_i.empty;
      ST_START: div_start = 1'b1;
      ST_DIV:   pop_o     = 1'b0;
      ST_DONE:  load_out  = out_free;
      default:  pop_o     = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      work_q <= head_i;
    end
  end

  // zero every summary field unless this frame closed a window
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      frame_index_o         <= work_q.frame_index;
      frame_plain_draws_o   <= work_q.plain_draws;
      frame_indexed_draws_o <= work_q.indexed_draws;
      frame_duration_ms_o   <= work_q.duration_ms;
      summary_valid_o       <= work_q.summary;
      if (work_q.summary) begin
        window_frames_o      <= work_q.win_frames;
        window_duration_ms_o <= work_q.win_duration_ms;
        fps_hundredths_o     <= quo_fps[FPS_W-1:0];
        min_draws_o          <= work_q.min_draws;
        max_draws_o          <= work_q.max_draws;
        avg_plain_draws_o    <= has_frames ? quo_plain : '0;
        avg_indexed_draws_o  <= has_frames ? quo_indexed : '0;
      end else begin
        window_frames_o      <= '0;
        window_duration_ms_o <= '0;
        fps_hundredths_o     <= '0;
        min_draws_o          <= '0;
        max_draws_o          <= '0;
        avg_plain_draws_o    <= '0;
        avg_indexed_draws_o  <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/frame_draw_statistics_window.sv */
// Frame and draw statistics window: top level. Instantiates fds_front,
// fds_queue and fds_back; depends on fds_pkg.
//
// Every event item (frame begin, plain draw, indexed draw, frame end) is
// accepted by the front end unless stalled; it keeps all frame and window
// counters; a stall appears only while the two-entry frame queue is full.
// Each frame end gives one result item. The back end sends a frame that does
// not close a window straight to its output state; for one that does, it first
// runs three restoring dividers side by side at one quotient bit per cycle
// (frame rate and both draw averages). The result sits in an output
// register, so the back end takes the next queued frame while a finished
// result still waits. The window length register takes effect on the next
// frame end and resets to 300 frames.
module frame_draw_statistics_window
  import fds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LEN_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        cmd_i,
  input  logic [DATA_W-1:0] time_ms_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DATA_W-1:0] frame_index_o,
  output logic [DATA_W-1:0] frame_plain_draws_o,
  output logic [DATA_W-1:0] frame_indexed_draws_o,
  output logic [DATA_W-1:0] frame_duration_ms_o,
  output logic              summary_valid_o,
  output logic [LEN_W-1:0]  window_frames_o,
  output logic [DATA_W-1:0] window_duration_ms_o,
  output logic [FPS_W-1:0]  fps_hundredths_o,
  output logic [DATA_W-1:0] min_draws_o,
  output logic [DATA_W-1:0] max_draws_o,
  output logic [DATA_W-1:0] avg_plain_draws_o,
  output logic [DATA_W-1:0] avg_indexed_draws_o
);

  fds_qstat_t qstat;
  fds_entry_t push_entry;
  fds_entry_t head_entry;
  logic       push;
  logic       pop;

  fds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .time_ms_i   (time_ms_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  fds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .qstat_o (qstat)
  );

  fds_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .qstat_i               (qstat),
    .head_i                (head_entry),
    .pop_o                 (pop),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .frame_index_o         (frame_index_o),
    .frame_plain_draws_o   (frame_plain_draws_o),
    .frame_indexed_draws_o (frame_indexed_draws_o),
    .frame_duration_ms_o   (frame_duration_ms_o),
    .summary_valid_o       (summary_valid_o),
    .window_frames_o       (window_frames_o),
    .window_duration_ms_o  (window_duration_ms_o),
    .fps_hundredths_o      (fps_hundredths_o),
    .min_draws_o           (min_draws_o),
    .max_draws_o           (max_draws_o),
    .avg_plain_draws_o     (avg_plain_draws_o),
    .avg_indexed_draws_o   (avg_indexed_draws_o)
  );

endmodule

/* verif/frame_draw_statistics_window_tb.sv */
`timescale 1ns / 100ps
// Testbench for frame_draw_statistics_window: drives event items, predicts every
// frame report and window summary in its own tracker, checks each result item.
// Depends on fds_pkg and the block's RTL only.
module frame_draw_statistics_window_tb;
  import fds_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_WINDOW    = 700;

  typedef struct packed {
    logic [DATA_W-1:0] frame_index;
    logic [DATA_W-1:0] plain_draws;
    logic [DATA_W-1:0] indexed_draws;
    logic [DATA_W-1:0] duration_ms;
    logic              summary;
    logic [LEN_W-1:0]  win_frames;
    logic [DATA_W-1:0] win_duration_ms;
    logic [FPS_W-1:0]  fps;
    logic [DATA_W-1:0] min_draws;
    logic [DATA_W-1:0] max_draws;
    logic [DATA_W-1:0] avg_plain;
    logic [DATA_W-1:0] avg_indexed;
  } frame_report_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [LEN_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        cmd_i       = CMD_BEGIN;
  logic [DATA_W-1:0] time_ms_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DATA_W-1:0] frame_index_o;
  logic [DATA_W-1:0] frame_plain_draws_o;
  logic [DATA_W-1:0] frame_indexed_draws_o;
  logic [DATA_W-1:0] frame_duration_ms_o;
  logic              summary_valid_o;
  logic [LEN_W-1:0]  window_frames_o;
  logic [DATA_W-1:0] window_duration_ms_o;
  logic [FPS_W-1:0]  fps_hundredths_o;
  logic [DATA_W-1:0] min_draws_o;
  logic [DATA_W-1:0] max_draws_o;
  logic [DATA_W-1:0] avg_plain_draws_o;
  logic [DATA_W-1:0] avg_indexed_draws_o;

  // Tracker state: frame and window counters as the block should hold them.
  logic [LEN_W-1:0]  win_len         = WIN_LEN_RESET;
  logic [DATA_W-1:0] seen_frames     = '0;
  logic [DATA_W-1:0] frame_plain     = '0;
  logic [DATA_W-1:0] frame_indexed   = '0;
  logic [DATA_W-1:0] frame_begin_ms  = '0;
  logic [LEN_W-1:0]  win_count       = '0;
  logic [DATA_W-1:0] win_begin_ms    = '0;
  logic [DATA_W-1:0] win_plain_sum   = '0;
  logic [DATA_W-1:0] win_indexed_sum = '0;
  logic [DATA_W-1:0] win_min         = ALL_ONES;
  logic [DATA_W-1:0] win_max         = '0;

  frame_report_t     pending_reports[$];
  logic [DATA_W-1:0] clock_ms       = '0;
  bit                idle_on        = 1'b1;
  int                hold_cycles    = 0;
  int                items_sent     = 0;
  int                reports_seen   = 0;
  int                summaries_seen = 0;
  int                errors         = 0;
  int                quiet_cycles   = 0;

  frame_draw_statistics_window dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cmd_i                (cmd_i),
    .time_ms_i            (time_ms_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .frame_index_o        (frame_index_o),
    .frame_plain_draws_o  (frame_plain_draws_o),
    .frame_indexed_draws_o(frame_indexed_draws_o),
    .frame_duration_ms_o  (frame_duration_ms_o),
    .summary_valid_o      (summary_valid_o),
    .window_frames_o      (window_frames_o),
    .window_duration_ms_o (window_duration_ms_o),
    .fps_hundredths_o     (fps_hundredths_o),
    .min_draws_o          (min_draws_o),
    .max_draws_o          (max_draws_o),
    .avg_plain_draws_o    (avg_plain_draws_o),
    .avg_indexed_draws_o  (avg_indexed_draws_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void restart_window(logic [DATA_W-1:0] now);
    win_count       = '0;
    win_begin_ms    = now;
    win_plain_sum   = '0;
    win_indexed_sum = '0;
    win_min         = ALL_ONES;
    win_max         = '0;
  endfunction

  // Advance the tracker by one accepted event; a frame end queues its report.
  function automatic void account_event(fds_cmd_e kind, logic [DATA_W-1:0] now);
    frame_report_t     rep;
    logic [DATA_W-1:0] draws;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] n_wide;
    logic [DATA_W-1:0] scaled;
    rep = '0;
    case (kind)
      CMD_BEGIN: begin
        if (seen_frames == '0) restart_window(now);
        frame_plain    = '0;
        frame_indexed  = '0;
        frame_begin_ms = now;
      end
      CMD_PLAIN:   frame_plain = frame_plain + 1'b1;
      CMD_INDEXED: frame_indexed = frame_indexed + 1'b1;
      default: begin
        draws           = frame_plain + frame_indexed;
        win_count       = win_count + 1'b1;
        win_plain_sum   = win_plain_sum + frame_plain;
        win_indexed_sum = win_indexed_sum + frame_indexed;
        if (draws < win_min) win_min = draws;
        if (draws > win_max) win_max = draws;
        rep.frame_index   = seen_frames;
        rep.plain_draws   = frame_plain;
        rep.indexed_draws = frame_indexed;
        rep.duration_ms   = now - frame_begin_ms;
        seen_frames       = seen_frames + 1'b1;
        if (win_count >= win_len) begin
          span = now - win_begin_ms;
          if (span == '0) span = DATA_W'(1);
          n_wide              = DATA_W'(win_count);
          scaled              = n_wide * FPS_SCALE;
          rep.summary         = 1'b1;
          rep.win_frames      = win_count;
          rep.win_duration_ms = span;
          rep.fps             = FPS_W'(scaled / span);
          rep.min_draws       = win_min;
          rep.max_draws       = win_max;
          if (n_wide != '0) begin
            rep.avg_plain   = win_plain_sum / n_wide;
            rep.avg_indexed = win_indexed_sum / n_wide;
          end
          restart_window(now);
        end
        pending_reports.push_back(rep);
      end
    endcase
  endfunction

  function automatic void check_field(string what, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_reports
    frame_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result item: expected none, actual frame_index %0h",
                 $time, frame_index_o);
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (want.summary) summaries_seen++;
        check_field("frame_index", want.frame_index, frame_index_o);
        check_field("frame_plain_draws", want.plain_draws, frame_plain_draws_o);
        check_field("frame_indexed_draws", want.indexed_draws, frame_indexed_draws_o);
        check_field("frame_duration_ms", want.duration_ms, frame_duration_ms_o);
        check_field("summary_valid", want.summary, summary_valid_o);
        check_field("window_frames", want.win_frames, window_frames_o);
        check_field("window_duration_ms", want.win_duration_ms, window_duration_ms_o);
        check_field("fps_hundredths", want.fps, fps_hundredths_o);
        check_field("min_draws", want.min_draws, min_draws_o);
        check_field("max_draws", want.max_draws, max_draws_o);
        check_field("avg_plain_draws", want.avg_plain, avg_plain_draws_o);
        check_field("avg_indexed_draws", want.avg_indexed, avg_indexed_draws_o);
      end
    end
  end

  // Receiver: a requested long hold first, otherwise random stall bursts.
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        out_stall_i <= 1'b1;
        burst--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        burst = $urandom_range(1, 19) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no item moved for %0d cycles, %0d reports outstanding",
                 $time, quiet_cycles, pending_reports.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_event(fds_cmd_e kind, logic [DATA_W-1:0] stamp);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= kind;
    time_ms_i  <= stamp;
    do @(posedge clk_i); while (in_stall_o);
    account_event(kind, stamp);
    items_sent++;
  endtask

  // Drop valid, wait out every expected report, then let the back end go quiet.
  task automatic wait_for_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window_length(logic [LEN_W-1:0] len);
    wait_for_reports();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_len = len;
  endtask

  function automatic logic [DATA_W-1:0] advance_clock();
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom();
      1, 2:    ;  // hold the timestamp for zero-length spans
      default: clock_ms = clock_ms + $urandom_range(1, 40);
    endcase
    return clock_ms;
  endfunction

  task automatic send_random_frame(int max_draws);
    int k;
    k = $urandom_range(0, max_draws);
    send_event(CMD_BEGIN, advance_clock());
    repeat (k) send_event($urandom_range(0, 1) ? CMD_PLAIN : CMD_INDEXED, advance_clock());
    send_event(CMD_END, advance_clock());
  endtask

  task automatic send_noise_item();
    send_event(fds_cmd_e'($urandom_range(0, 3)),
               $urandom_range(0, 1) ? $urandom() : advance_clock());
  endtask

  // Default length: first-begin restarts, ends without begin, stray draws, time wrap.
  task automatic test_frame_edges();
    send_event(CMD_BEGIN, 32'd100);
    send_event(CMD_PLAIN, 32'd110);
    send_event(CMD_BEGIN, 32'd200);
    send_event(CMD_INDEXED, 32'd210);
    send_event(CMD_INDEXED, 32'd220);
    send_event(CMD_END, 32'd250);
    send_event(CMD_PLAIN, 32'd255);
    send_event(CMD_END, 32'd260);
    send_event(CMD_BEGIN, 32'hFFFF_FFFF);
    send_event(CMD_PLAIN, 32'hFFFF_FFFF);
    send_event(CMD_END, 32'h0000_0000);
    send_event(CMD_BEGIN, 32'h0000_0000);
    send_event(CMD_END, 32'hFFFF_FFFF);
    send_event(CMD_END, 32'h5555_AAAA);
  endtask

  // Lengths below the current count, zero and one; a zero-length frame.
  task automatic test_window_close_rules();
    set_window_length(LEN_W'(2));
    send_event(CMD_BEGIN, 32'h8000_0000);
    send_event(CMD_END, 32'h8000_0010);
    set_window_length('0);
    send_event(CMD_BEGIN, 32'h1234_5678);
    send_event(CMD_INDEXED, 32'h1234_5678);
    send_event(CMD_END, 32'h1234_5678);
    send_event(CMD_END, 32'h1234_5679);
    set_window_length(LEN_W'(1));
    send_event(CMD_BEGIN, 32'hAAAA_5555);
    send_event(CMD_PLAIN, 32'hAAAA_5556);
    send_event(CMD_END, 32'hAAAA_5557);
  endtask

  // Long window closed in zero time: frame rate reaches the top bit of its field.
  task automatic test_long_window();
    int ends;
    set_window_length(LEN_W'(1));
    send_event(CMD_BEGIN, ALL_ONES);
    send_event(CMD_END, ALL_ONES);
    set_window_length(LEN_W'(LONG_WINDOW));
    ends = 0;
    while (ends < LONG_WINDOW) begin
      if ($urandom_range(0, 49) == 0) begin
        send_event($urandom_range(0, 1) ? CMD_PLAIN : CMD_INDEXED, ALL_ONES);
      end else begin
        send_event(CMD_END, ALL_ONES);
        ends++;
      end
    end
  endtask

  // Hold the receiver off while frames keep coming, so the input stalls.
  task automatic test_output_hold();
    set_window_length(LEN_W'(2));
    idle_on     = 1'b0;
    hold_cycles = 400;
    repeat (30) send_random_frame(2);
    wait_for_reports();
    idle_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int phase_end;
    for (int phase = 0; phase < 2; phase++) begin
      case ($urandom_range(0, 9))
        0:       set_window_length('0);
        1:       set_window_length(LEN_W'($urandom_range(100, 1023)));
        default: set_window_length(LEN_W'($urandom_range(1, 12)));
      endcase
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_end = items_sent + 90;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 85) send_random_frame((phase % 2) ? 30 : 6);
        else send_noise_item();
      end
    end
  endtask

  task automatic test_full_rate();
    int phase_end;
    set_window_length(LEN_W'(4));
    idle_on   = 1'b0;
    phase_end = items_sent + 150;
    while (items_sent < phase_end) begin
      if ($urandom_range(0, 9) != 0) send_random_frame(5);
      else send_noise_item();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_edges();
    test_window_close_rules();
    test_long_window();
    test_output_hold();
    test_random_phases();
    test_full_rate();
    wait_for_reports();
    $display("Sent %0d event items; checked %0d frame reports, %0d with window summaries,",
             items_sent, reports_seen, summaries_seen);
    $display("over window lengths 0, 1, %0d, the reset length and random ones, with stalls.",
             LONG_WINDOW);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
